// File: sv/qvr_pkg.sv
// ============================================================================
// qvr_pkg
// Shared types and constants for the quaternion vector rotate unit: field
// widths, configuration register indexes and the request/result structs.
// ============================================================================
`default_nettype none

package qvr_pkg;

  // Quaternion component width (two's complement) and vector component width
  localparam int QUAT_W = 16;
  localparam int VEC_W  = 24;

  // Default number of fraction bits in a quaternion component (Q1.14)
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // Configuration port index width; indexes past the register list are ignored
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_X = 3'd0,
    REG_QUAT_Y = 3'd1,
    REG_QUAT_Z = 3'd2,
    REG_QUAT_W = 3'd3
  } cfg_reg_t;

  // Rotation mode of one request
  localparam logic MODE_ROTATE    = 1'b0;
  localparam logic MODE_CONJUGATE = 1'b1;

  // One request: mode and the vector to rotate
  typedef struct packed {
    logic                    mode;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } in_req_t;

  // One result: rotated, rounded and saturated vector plus clip flag
  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic                    saturated;
  } out_res_t;

endpackage : qvr_pkg

`default_nettype wire

// File: sv/quaternion_vector_rotate_unit.sv
// ============================================================================
// quaternion_vector_rotate_unit
// Rotates 3-D vectors by the rotation matrix of a Q1.14 quaternion, or by its
// transpose (conjugate), with round-half-up and saturation to vector width.
// ============================================================================
//
//   Channel  Ports                              Direction  Transfer
//   -------  ---------------------------------  ---------  ----------------------
//   input    start, busy, in_req                in         start && !busy
//   result   out_strobe, out_res                out        out_strobe, one cycle
//   config   cfg_we, cfg_index, cfg_wdata       in         cfg_we, no wait
//
// One request per clock; busy is never raised. A result passes through five
// register stages plus the output register; the third stage holds the
// 34 x 24 coefficient multipliers. rst_n (synchronous, active low) clears
// the stage valid bits and loads the identity quaternion. The result side
// cannot stall, so the pipeline never holds. Quaternion writes take effect
// for the request taken next cycle.
//
`default_nettype none

module quaternion_vector_rotate_unit #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // request channel
  input  wire                          start,
  output logic                         busy,
  input  qvr_pkg::in_req_t             in_req,
  // result channel
  output logic                         out_strobe,
  output qvr_pkg::out_res_t            out_res,
  // configuration write port
  input  wire                          cfg_we,
  input  wire [qvr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [qvr_pkg::QUAT_W-1:0]    cfg_wdata
);

  import qvr_pkg::*;

  // --------------------------------------------------------------------------
  // Widths
  // --------------------------------------------------------------------------
  localparam int PROD_W = 2 * QUAT_W;               // raw q*q product
  localparam int COEF_W = PROD_W + 2;               // doubled sum of two products
  localparam int TERM_W = COEF_W + VEC_W;           // coefficient * component
  localparam int SUM_W  = TERM_W + 2;               // three terms
  localparam int SHIFT  = 2 * QUAT_FRAC_BITS;       // fraction bits of the matrix
  localparam int VSH_W  = VEC_W + SHIFT;            // component scaled by 1.0
  localparam int ACC_W  = ((SUM_W > VSH_W) ? SUM_W : VSH_W) + 2;
  localparam int RND_W  = ACC_W - SHIFT;            // rounded row value
  localparam int PIPE_LAT = 6;

  localparam logic [63:0]         QUAT_ONE_FULL = 64'd1 << QUAT_FRAC_BITS;
  localparam logic [QUAT_W-1:0]   QUAT_ONE      = QUAT_ONE_FULL[QUAT_W-1:0];
  localparam logic [ACC_W-1:0]    HALF          = {{(ACC_W-1){1'b0}}, 1'b1} << (SHIFT-1);
  localparam logic [VEC_W-1:0]    VEC_MAX       = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic [VEC_W-1:0]    VEC_MIN       = {1'b1, {(VEC_W-1){1'b0}}};

  // --------------------------------------------------------------------------
  // Quaternion registers
  // --------------------------------------------------------------------------
  logic signed [QUAT_W-1:0] quat_x_r, quat_y_r, quat_z_r, quat_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_x_r <= '0;
      quat_y_r <= '0;
      quat_z_r <= '0;
      quat_w_r <= QUAT_ONE;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_QUAT_X: quat_x_r <= cfg_wdata;
        REG_QUAT_Y: quat_y_r <= cfg_wdata;
        REG_QUAT_Z: quat_z_r <= cfg_wdata;
        REG_QUAT_W: quat_w_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Every request is taken on arrival
  assign busy = 1'b0;

  logic take;
  assign take = start && !busy;

  // --------------------------------------------------------------------------
  // Valid bits
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= take;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      v5_r         <= v4_r;
      out_strobe_r <= v5_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: nine quaternion products, capture vector
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] pxx_r, pyy_r, pzz_r, pxy_r, pyz_r, pzx_r;
  logic signed [PROD_W-1:0] pxw_r, pyw_r, pzw_r;
  logic                     mode1_r;
  logic signed [VEC_W-1:0]  vec1_r [3];

  always_ff @(posedge clk) begin
    if (take) begin
      pxx_r     <= PROD_W'(quat_x_r) * PROD_W'(quat_x_r);
      pyy_r     <= PROD_W'(quat_y_r) * PROD_W'(quat_y_r);
      pzz_r     <= PROD_W'(quat_z_r) * PROD_W'(quat_z_r);
      pxy_r     <= PROD_W'(quat_x_r) * PROD_W'(quat_y_r);
      pyz_r     <= PROD_W'(quat_y_r) * PROD_W'(quat_z_r);
      pzx_r     <= PROD_W'(quat_z_r) * PROD_W'(quat_x_r);
      pxw_r     <= PROD_W'(quat_x_r) * PROD_W'(quat_w_r);
      pyw_r     <= PROD_W'(quat_y_r) * PROD_W'(quat_w_r);
      pzw_r     <= PROD_W'(quat_z_r) * PROD_W'(quat_w_r);
      mode1_r   <= in_req.mode;
      vec1_r[0] <= in_req.vec_x;
      vec1_r[1] <= in_req.vec_y;
      vec1_r[2] <= in_req.vec_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: matrix coefficients. Diagonal entries hold the part subtracted
  // from 1.0; the conjugate flips the sign of the w cross terms.
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0] x2, y2, z2, xy2, yz2, zx2, xw2, yw2, zw2;
  logic signed [COEF_W-1:0] xws, yws, zws;
  logic signed [COEF_W-1:0] coef_nxt [3][3];
  logic signed [COEF_W-1:0] coef2_r  [3][3];
  logic signed [VEC_W-1:0]  vec2_r   [3];

  always_comb begin
    x2  = COEF_W'(pxx_r) <<< 1;
    y2  = COEF_W'(pyy_r) <<< 1;
    z2  = COEF_W'(pzz_r) <<< 1;
    xy2 = COEF_W'(pxy_r) <<< 1;
    yz2 = COEF_W'(pyz_r) <<< 1;
    zx2 = COEF_W'(pzx_r) <<< 1;
    xw2 = COEF_W'(pxw_r) <<< 1;
    yw2 = COEF_W'(pyw_r) <<< 1;
    zw2 = COEF_W'(pzw_r) <<< 1;
    xws = (mode1_r == MODE_CONJUGATE) ? -xw2 : xw2;
    yws = (mode1_r == MODE_CONJUGATE) ? -yw2 : yw2;
    zws = (mode1_r == MODE_CONJUGATE) ? -zw2 : zw2;
    coef_nxt[0][0] = y2 + z2;
    coef_nxt[0][1] = xy2 - zws;
    coef_nxt[0][2] = zx2 + yws;
    coef_nxt[1][0] = xy2 + zws;
    coef_nxt[1][1] = z2 + x2;
    coef_nxt[1][2] = yz2 - xws;
    coef_nxt[2][0] = zx2 - yws;
    coef_nxt[2][1] = yz2 + xws;
    coef_nxt[2][2] = x2 + y2;
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      coef2_r <= coef_nxt;
      vec2_r  <= vec1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: nine coefficient * component products
  // --------------------------------------------------------------------------
  logic signed [TERM_W-1:0] term3_r [3][3];
  logic signed [VEC_W-1:0]  vec3_r  [3];

  always_ff @(posedge clk) begin
    if (v2_r) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          term3_r[r][c] <= TERM_W'(coef2_r[r][c]) * TERM_W'(vec2_r[c]);
        end
      end
      vec3_r <= vec2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: row sums of the off-diagonal terms less the diagonal correction
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum4_r [3];
  logic signed [VEC_W-1:0] vec4_r [3];

  always_ff @(posedge clk) begin
    if (v3_r) begin
      sum4_r[0] <= SUM_W'(term3_r[0][1]) + SUM_W'(term3_r[0][2]) - SUM_W'(term3_r[0][0]);
      sum4_r[1] <= SUM_W'(term3_r[1][0]) + SUM_W'(term3_r[1][2]) - SUM_W'(term3_r[1][1]);
      sum4_r[2] <= SUM_W'(term3_r[2][0]) + SUM_W'(term3_r[2][1]) - SUM_W'(term3_r[2][2]);
      vec4_r    <= vec3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: add the 1.0 term and the rounding half, drop fraction bits
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc5 [3];
  logic signed [RND_W-1:0] rnd5_r [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc5[r] = (ACC_W'(vec4_r[r]) <<< SHIFT) + ACC_W'(sum4_r[r]) + $signed(HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r) begin
      for (int r = 0; r < 3; r++) begin
        rnd5_r[r] <= acc5[r][ACC_W-1:SHIFT];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: saturate to vector width into the output register
  // --------------------------------------------------------------------------
  logic [VEC_W-1:0] clip6 [3];
  logic [2:0]       over6;
  out_res_t         out_res_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      over6[r] = (rnd5_r[r][RND_W-1:VEC_W-1] != {(RND_W-VEC_W+1){1'b0}}) &&
                 (rnd5_r[r][RND_W-1:VEC_W-1] != {(RND_W-VEC_W+1){1'b1}});
      if (!over6[r]) begin
        clip6[r] = rnd5_r[r][VEC_W-1:0];
      end else if (rnd5_r[r][RND_W-1]) begin
        clip6[r] = VEC_MIN;
      end else begin
        clip6[r] = VEC_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v5_r) begin
      out_res_r.out_x     <= clip6[0];
      out_res_r.out_y     <= clip6[1];
      out_res_r.out_z     <= clip6[2];
      out_res_r.saturated <= |over6;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // each taken request yields exactly one result after the fixed latency
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##PIPE_LAT out_strobe)
    else $error("request did not produce a result after the pipeline latency");

  a_result_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(take, PIPE_LAT))
    else $error("result strobe without a matching request");

  // a clip flag means some component sits at a rail
  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.saturated) |->
      (out_res.out_x == VEC_MAX || out_res.out_x == VEC_MIN ||
       out_res.out_y == VEC_MAX || out_res.out_y == VEC_MIN ||
       out_res.out_z == VEC_MAX || out_res.out_z == VEC_MIN))
    else $error("saturated flag set with no component at a rail");

endmodule : quaternion_vector_rotate_unit

`default_nettype wire
